FILE: design/fas_pkg.sv
`default_nettype none
package fas_pkg;
  localparam int unsigned MantWidthDef = 64;
  localparam int unsigned ExpWidthDef  = 16;

  typedef enum logic {
    CMD_ADD = 1'b0,
    CMD_SUB = 1'b1
  } cmd_e;
endpackage
`default_nettype wire

FILE: design/fas_if.sv
`default_nettype none
interface fas_in_if #(
  parameter int unsigned MantWidth = 64,
  parameter int unsigned ExpWidth  = 16
);
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic                 a_negative;
  logic                 a_zero;
  logic [ExpWidth-1:0]  a_exponent;
  logic [MantWidth-1:0] a_mantissa;
  logic                 b_negative;
  logic                 b_zero;
  logic [ExpWidth-1:0]  b_exponent;
  logic [MantWidth-1:0] b_mantissa;
  modport source (output valid, command, a_negative, a_zero, a_exponent, a_mantissa,
                  b_negative, b_zero, b_exponent, b_mantissa, input ready);
  modport sink (input valid, command, a_negative, a_zero, a_exponent, a_mantissa,
                b_negative, b_zero, b_exponent, b_mantissa, output ready);
endinterface

interface fas_out_if #(
  parameter int unsigned MantWidth = 64,
  parameter int unsigned ExpWidth  = 16
);
  logic                 valid;
  logic                 ready;
  logic                 r_negative;
  logic                 r_zero;
  logic [ExpWidth-1:0]  r_exponent;
  logic [MantWidth-1:0] r_mantissa;
  modport source (output valid, r_negative, r_zero, r_exponent, r_mantissa, input ready);
  modport sink (input valid, r_negative, r_zero, r_exponent, r_mantissa, output ready);
endinterface
`default_nettype wire

FILE: design/float_add_sub_64bit_mantissa.sv
`default_nettype none
// Floating adder and subtractor on sign, zero flag, signed exponent and normalised mantissa.
// It is a three-stage pipeline (align, add or subtract with leading-zero count, normalise)
// that takes one word every cycle unless the output stalls, and registers each result in the
// align, add-or-subtract and normalise stages in turn. The whole pipeline advances when the
// output register is empty or being taken, so a stall at the output holds every stage.
module float_add_sub_64bit_mantissa #(
  parameter int unsigned MantWidth = fas_pkg::MantWidthDef,
  parameter int unsigned ExpWidth  = fas_pkg::ExpWidthDef
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  fas_in_if.sink   in_if,
  fas_out_if.source out_if
);
  import fas_pkg::*;

  localparam int unsigned LzWidth = $clog2(MantWidth);

  logic adv;
  logic v1_q, v2_q, v3_q;

  logic                 s1_bypass, s1_sub, s1_neg, s1_zero;
  logic [ExpWidth-1:0]  s1_exp;
  logic [MantWidth-1:0] s1_x, s1_y;
  logic                 s2_neg, s2_zero, s2_carry, s2_norm;
  logic [ExpWidth-1:0]  s2_exp;
  logic [MantWidth-1:0] s2_m;
  logic [LzWidth-1:0]   s2_lz;

  assign adv         = !v3_q || out_if.ready;
  assign in_if.ready = adv;
  assign out_if.valid = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_if.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  fas_align #(.MantWidth(MantWidth), .ExpWidth(ExpWidth)) u_align (
    .clk_i, .en_i(adv),
    .command_i(in_if.command), .a_negative_i(in_if.a_negative), .a_zero_i(in_if.a_zero),
    .a_exponent_i(in_if.a_exponent), .a_mantissa_i(in_if.a_mantissa),
    .b_negative_i(in_if.b_negative), .b_zero_i(in_if.b_zero),
    .b_exponent_i(in_if.b_exponent), .b_mantissa_i(in_if.b_mantissa),
    .bypass_o(s1_bypass), .sub_o(s1_sub), .neg_o(s1_neg), .zero_o(s1_zero),
    .exp_o(s1_exp), .x_o(s1_x), .y_o(s1_y)
  );

  fas_addsub #(.MantWidth(MantWidth), .ExpWidth(ExpWidth)) u_addsub (
    .clk_i, .en_i(adv),
    .bypass_i(s1_bypass), .sub_i(s1_sub), .neg_i(s1_neg), .zero_i(s1_zero),
    .exp_i(s1_exp), .x_i(s1_x), .y_i(s1_y),
    .neg_o(s2_neg), .zero_o(s2_zero), .carry_o(s2_carry), .norm_o(s2_norm),
    .exp_o(s2_exp), .m_o(s2_m), .lz_o(s2_lz)
  );

  fas_norm #(.MantWidth(MantWidth), .ExpWidth(ExpWidth)) u_norm (
    .clk_i, .en_i(adv),
    .neg_i(s2_neg), .zero_i(s2_zero), .carry_i(s2_carry), .norm_i(s2_norm),
    .exp_i(s2_exp), .m_i(s2_m), .lz_i(s2_lz),
    .neg_o(out_if.r_negative), .zero_o(out_if.r_zero),
    .exp_o(out_if.r_exponent), .m_o(out_if.r_mantissa)
  );

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !out_if.ready |=> v3_q && $stable(v2_q) && $stable(v1_q))
    else $error("pipeline moved during an output stall");
  a_zero_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && out_if.r_zero |-> out_if.r_mantissa == '0)
    else $error("zero result with nonzero mantissa");
  a_norm_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(adv) && $past(v2_q) && $past(s2_norm) |-> out_if.r_mantissa[MantWidth-1])
    else $error("normalised difference lacks its top bit");
endmodule
`default_nettype wire

FILE: design/fas_align.sv
`default_nettype none
// Stage one: swap by exponent, align the smaller mantissa and settle the zero shortcuts.
module fas_align #(
  parameter int unsigned MantWidth = 64,
  parameter int unsigned ExpWidth  = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic                 command_i,
  input  wire logic                 a_negative_i,
  input  wire logic                 a_zero_i,
  input  wire logic [ExpWidth-1:0]  a_exponent_i,
  input  wire logic [MantWidth-1:0] a_mantissa_i,
  input  wire logic                 b_negative_i,
  input  wire logic                 b_zero_i,
  input  wire logic [ExpWidth-1:0]  b_exponent_i,
  input  wire logic [MantWidth-1:0] b_mantissa_i,
  output logic                      bypass_o,
  output logic                      sub_o,
  output logic                      neg_o,
  output logic                      zero_o,
  output logic [ExpWidth-1:0]       exp_o,
  output logic [MantWidth-1:0]      x_o,
  output logic [MantWidth-1:0]      y_o
);
  import fas_pkg::*;

  localparam int unsigned DiffWidth = ExpWidth + 1;

  logic signed [DiffWidth-1:0] diff;
  logic [DiffWidth-1:0]        shift_amt;
  logic                        b_big;
  logic [MantWidth-1:0]        small_m, shifted;
  logic                        bypass_d, sub_d, neg_d, zero_d;
  logic [ExpWidth-1:0]         exp_d;
  logic [MantWidth-1:0]        x_d, y_d;

  always_comb begin
    diff    = DiffWidth'($signed(b_exponent_i)) - DiffWidth'($signed(a_exponent_i));
    b_big   = diff > 0;
    shift_amt = b_big ? diff : -diff;
    small_m = b_big ? a_mantissa_i : b_mantissa_i;
    shifted = (shift_amt < DiffWidth'(MantWidth)) ? (small_m >> shift_amt) : '0;
    sub_d   = a_negative_i ^ b_negative_i ^ (command_i == CMD_SUB);
    bypass_d = a_zero_i | b_zero_i;
    neg_d   = a_negative_i;
    zero_d  = 1'b0;
    exp_d   = b_big ? b_exponent_i : a_exponent_i;
    x_d     = b_big ? shifted : a_mantissa_i;
    y_d     = b_big ? b_mantissa_i : shifted;
    if (a_zero_i && b_zero_i) begin
      zero_d = 1'b1;
      exp_d  = '0;
      x_d    = '0;
    end else if (b_zero_i) begin
      exp_d = a_exponent_i;
      x_d   = a_mantissa_i;
    end else if (a_zero_i) begin
      neg_d = b_negative_i ^ (command_i == CMD_SUB);
      exp_d = b_exponent_i;
      x_d   = b_mantissa_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bypass_o <= bypass_d;
      sub_o    <= sub_d;
      neg_o    <= neg_d;
      zero_o   <= zero_d;
      exp_o    <= exp_d;
      x_o      <= x_d;
      y_o      <= y_d;
    end
  end
endmodule
`default_nettype wire

FILE: design/fas_addsub.sv
`default_nettype none
// Stage two: add or subtract the aligned mantissas and count leading zeros.
module fas_addsub #(
  parameter int unsigned MantWidth = 64,
  parameter int unsigned ExpWidth  = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic                 bypass_i,
  input  wire logic                 sub_i,
  input  wire logic                 neg_i,
  input  wire logic                 zero_i,
  input  wire logic [ExpWidth-1:0]  exp_i,
  input  wire logic [MantWidth-1:0] x_i,
  input  wire logic [MantWidth-1:0] y_i,
  output logic                      neg_o,
  output logic                      zero_o,
  output logic                      carry_o,
  output logic                      norm_o,
  output logic [ExpWidth-1:0]       exp_o,
  output logic [MantWidth-1:0]      m_o,
  output logic [$clog2(MantWidth)-1:0] lz_o
);
  import fas_pkg::*;

  localparam int unsigned LzWidth = $clog2(MantWidth);

  logic [MantWidth:0]   sum;
  logic [MantWidth-1:0] diff;
  logic                 y_big;
  logic [LzWidth-1:0]   lz;
  logic                 neg_d, zero_d, carry_d, norm_d;
  logic [ExpWidth-1:0]  exp_d;
  logic [MantWidth-1:0] m_d;

  always_comb begin
    sum   = {1'b0, x_i} + {1'b0, y_i};
    y_big = x_i < y_i;
    diff  = y_big ? (y_i - x_i) : (x_i - y_i);
    lz    = '0;
    for (int i = 0; i < MantWidth; i++) begin
      if (diff[i]) lz = LzWidth'(MantWidth - 1 - i);
    end
    neg_d   = neg_i;
    zero_d  = zero_i;
    carry_d = 1'b0;
    norm_d  = 1'b0;
    exp_d   = exp_i;
    m_d     = x_i;
    if (!bypass_i) begin
      if (sub_i) begin
        neg_d  = neg_i ^ y_big;
        m_d    = diff;
        norm_d = 1'b1;
        if (diff == '0) begin
          zero_d = 1'b1;
          exp_d  = '0;
          norm_d = 1'b0;
        end
      end else begin
        m_d     = sum[MantWidth-1:0];
        carry_d = sum[MantWidth];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_o   <= neg_d;
      zero_o  <= zero_d;
      carry_o <= carry_d;
      norm_o  <= norm_d;
      exp_o   <= exp_d;
      m_o     <= m_d;
      lz_o    <= lz;
    end
  end
endmodule
`default_nettype wire

FILE: design/fas_norm.sv
`default_nettype none
// Stage three: normalise by the leading-zero count or fold back a carry.
module fas_norm #(
  parameter int unsigned MantWidth = 64,
  parameter int unsigned ExpWidth  = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic                 neg_i,
  input  wire logic                 zero_i,
  input  wire logic                 carry_i,
  input  wire logic                 norm_i,
  input  wire logic [ExpWidth-1:0]  exp_i,
  input  wire logic [MantWidth-1:0] m_i,
  input  wire logic [$clog2(MantWidth)-1:0] lz_i,
  output logic                      neg_o,
  output logic                      zero_o,
  output logic [ExpWidth-1:0]       exp_o,
  output logic [MantWidth-1:0]      m_o
);
  import fas_pkg::*;

  localparam int unsigned WideExp = ExpWidth + 2;

  logic signed [WideExp-1:0] e_wide, e_max, e_min, e_low, e_up;
  logic [MantWidth-1:0]      inc;
  logic [ExpWidth-1:0]       exp_d;
  logic [MantWidth-1:0]      m_d;

  always_comb begin
    e_max  = WideExp'($signed({1'b0, {(ExpWidth-1){1'b1}}}));
    e_min  = WideExp'($signed({1'b1, {(ExpWidth-1){1'b0}}}));
    e_wide = WideExp'($signed(exp_i));
    e_low  = e_wide - WideExp'(lz_i);
    inc    = m_i + MantWidth'(1);
    // A wrapped increment raises the exponent twice; the raised exponent saturates at the top.
    e_up   = e_wide + ((inc == '0) ? WideExp'(2) : WideExp'(1));
    exp_d  = exp_i;
    m_d    = m_i;
    if (norm_i) begin
      m_d   = m_i << lz_i;
      exp_d = (e_low < e_min) ? e_min[ExpWidth-1:0] : e_low[ExpWidth-1:0];
    end else if (carry_i) begin
      m_d   = {1'b1, inc[MantWidth-1:1]};
      exp_d = (e_up > e_max) ? e_max[ExpWidth-1:0] : e_up[ExpWidth-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_o  <= neg_i;
      zero_o <= zero_i;
      exp_o  <= exp_d;
      m_o    <= m_d;
    end
  end
endmodule
`default_nettype wire

FILE: test/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fas_pkg::*;

  localparam int MW = 64;
  localparam int EW = 16;
  localparam int EXP_HI = 32767;
  localparam int EXP_LO = -32768;
  localparam int N_RANDOM = 1430;

  typedef struct {
    cmd_e            cmd;
    bit              an;
    bit              az;
    logic [EW-1:0]   ae;
    logic [MW-1:0]   am;
    bit              bn;
    bit              bz;
    logic [EW-1:0]   be;
    logic [MW-1:0]   bm;
  } operands_t;

  typedef struct {
    bit            neg;
    bit            zero;
    logic [EW-1:0] e;
    logic [MW-1:0] m;
  } sum_t;

  typedef struct {
    operands_t op;
    bit        typed;
    sum_t      want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  fas_in_if  #(.MantWidth(MW), .ExpWidth(EW)) in_if ();
  fas_out_if #(.MantWidth(MW), .ExpWidth(EW)) out_if ();

  float_add_sub_64bit_mantissa #(.MantWidth(MW), .ExpWidth(EW)) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if.sink),
    .out_if(out_if.source)
  );

  always #10 clk_i = ~clk_i;

  sum_t      sums_pending[$];
  row_t      directed[$];
  int        errors = 0;
  int        n_checked = 0;
  int        n_cancel = 0;
  bit        hold_off = 1'b0;
  bit        calm = 1'b0;

  function automatic int exp_raise(int e);
    return (e >= EXP_HI) ? EXP_HI : e + 1;
  endfunction

  function automatic sum_t add_sub(operands_t op);
    sum_t          r;
    int            ea, eb, e, d;
    logic [MW-1:0] x, y, m;
    logic [MW:0]   s;
    bit            neg;
    ea = $signed(op.ae);
    eb = $signed(op.be);
    if (op.az && op.bz) return '{op.an, 1'b1, '0, '0};
    if (op.bz) return '{op.an, 1'b0, op.ae, op.am};
    if (op.az) return '{op.bn ^ op.cmd, 1'b0, op.be, op.bm};
    if (ea < eb) begin
      d = eb - ea;
      e = eb;
      x = (d < MW) ? op.am >> d : '0;
      y = op.bm;
    end else begin
      d = ea - eb;
      e = ea;
      x = op.am;
      y = (d < MW) ? op.bm >> d : '0;
    end
    neg = op.an;
    if (op.an ^ op.bn ^ op.cmd) begin
      if (x < y) begin
        neg = ~neg;
        m = y - x;
      end else begin
        m = x - y;
      end
      if (m == '0) return '{neg, 1'b1, '0, '0};
      while (!m[MW-1]) begin
        m = m << 1;
        if (e > EXP_LO) e--;
      end
    end else begin
      s = {1'b0, x} + {1'b0, y};
      m = s[MW-1:0];
      if (s[MW]) begin
        m = m + 1'b1;
        if (m == '0) e = exp_raise(e);
        m = (m >> 1) | {1'b1, {(MW-1){1'b0}}};
        e = exp_raise(e);
      end
    end
    r.neg = neg;
    r.zero = 1'b0;
    r.e = e[EW-1:0];
    r.m = m;
    return r;
  endfunction

  function automatic logic [MW-1:0] rand_mant(bit normal);
    logic [MW-1:0] m;
    m = {$urandom, $urandom};
    if (normal) m[MW-1] = 1'b1;
    return m;
  endfunction

  function automatic operands_t random_operands();
    operands_t op;
    int        pick, ea, eb;
    pick = $urandom_range(0, 99);
    op.cmd = cmd_e'($urandom_range(0, 1));
    op.an = $urandom_range(0, 1);
    op.bn = $urandom_range(0, 1);
    op.az = ($urandom_range(0, 19) == 0);
    op.bz = ($urandom_range(0, 19) == 0);
    op.am = rand_mant($urandom_range(0, 9) != 0);
    op.bm = rand_mant($urandom_range(0, 9) != 0);
    if (pick < 10) begin
      ea = $urandom_range(0, 65535) - 32768;
      eb = $urandom_range(0, 65535) - 32768;
    end else if (pick < 20) begin
      ea = ($urandom_range(0, 1) != 0) ? EXP_HI - $urandom_range(0, 3)
                                       : EXP_LO + $urandom_range(0, 3);
      eb = ea + $urandom_range(0, 6) - 3;
    end else begin
      ea = $urandom_range(0, 2000) - 1000;
      eb = ea + $urandom_range(0, 140) - 70;
    end
    // Near-equal mantissas drive deep cancellation and long renormalisation.
    if (pick >= 85) begin
      eb = ea;
      op.bm = op.am ^ (64'h1 << $urandom_range(0, 63)) ^ $urandom_range(0, 3);
      if (pick >= 95) op.bm = op.am;
    end
    op.ae = ea[EW-1:0];
    op.be = eb[EW-1:0];
    return op;
  endfunction

  function automatic operands_t ops(cmd_e c, bit an, bit az, int ae, logic [MW-1:0] am,
                                    bit bn, bit bz, int be, logic [MW-1:0] bm);
    operands_t op;
    op = '{c, an, az, ae[EW-1:0], am, bn, bz, be[EW-1:0], bm};
    return op;
  endfunction

  task automatic add_row(operands_t op, bit typed, sum_t want);
    directed.push_back('{op, typed, want});
  endtask

  function automatic int idle_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  initial begin
    localparam logic [MW-1:0] TOP = 64'h8000_0000_0000_0000;
    localparam logic [MW-1:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    operands_t op;
    int        gap;
    int        i;
    sum_t      none;
    none = '{0, 0, '0, '0};

    // Zero shortcuts, cancellation and a saturating carry have results that can be written down directly.
    add_row(ops(CMD_ADD, 1, 1, 5, ONES, 0, 1, 7, TOP), 1, '{1, 1, '0, '0});
    add_row(ops(CMD_SUB, 0, 0, -3, ONES, 1, 1, 9, TOP), 1, '{0, 0, -16'sd3, ONES});
    add_row(ops(CMD_SUB, 1, 1, 2, TOP, 0, 0, EXP_HI, ONES), 1, '{1, 0, 16'h7FFF, ONES});
    add_row(ops(CMD_ADD, 0, 1, 2, TOP, 1, 0, EXP_LO, TOP), 1, '{1, 0, 16'h8000, TOP});
    add_row(ops(CMD_SUB, 0, 0, 11, ONES, 0, 0, 11, ONES), 1, '{0, 1, '0, '0});
    add_row(ops(CMD_ADD, 1, 0, -4, TOP, 0, 0, -4, TOP), 1, '{1, 1, '0, '0});
    add_row(ops(CMD_ADD, 0, 0, EXP_HI, ONES, 0, 0, EXP_HI, ONES), 1,
            '{0, 0, 16'h7FFF, ONES});
    add_row(ops(CMD_ADD, 0, 0, 0, TOP, 0, 0, 0, TOP), 0, none);
    add_row(ops(CMD_ADD, 0, 0, 0, ONES, 0, 0, 0, 64'h1), 0, none);
    add_row(ops(CMD_ADD, 0, 0, 64, TOP, 0, 0, 0, ONES), 0, none);
    add_row(ops(CMD_ADD, 0, 0, 63, TOP, 0, 0, 0, ONES), 0, none);
    add_row(ops(CMD_SUB, 0, 0, 0, ONES, 0, 0, 64, TOP), 0, none);
    add_row(ops(CMD_SUB, 1, 0, EXP_LO, 64'hC000_0000_0000_0000, 1, 0, EXP_LO,
                64'hBFFF_FFFF_FFFF_FFFF), 0, none);
    add_row(ops(CMD_ADD, 0, 0, EXP_LO, TOP, 0, 0, EXP_HI, TOP), 0, none);
    add_row(ops(CMD_SUB, 1, 0, EXP_HI, TOP, 0, 0, EXP_LO, ONES), 0, none);
    add_row(ops(CMD_ADD, 0, 0, 3, 64'h1, 0, 0, 3, 64'h2), 0, none);
    add_row(ops(CMD_SUB, 0, 0, 3, 64'h5, 0, 0, 3, 64'h1), 0, none);
    add_row(ops(CMD_ADD, 1, 0, 10, 64'h0, 0, 0, 10, 64'h0), 0, none);
    add_row(ops(CMD_SUB, 0, 0, 1, 64'h0, 0, 0, 0, TOP), 0, none);
    add_row(ops(CMD_ADD, 1, 0, -100, 64'hAAAA_AAAA_AAAA_AAAA, 0, 0, -99,
                64'h5555_5555_5555_5555), 0, none);

    in_if.valid = 1'b0;
    in_if.command = CMD_ADD;
    in_if.a_negative = 1'b0;
    in_if.a_zero = 1'b0;
    in_if.a_exponent = '0;
    in_if.a_mantissa = '0;
    in_if.b_negative = 1'b0;
    in_if.b_zero = 1'b0;
    in_if.b_exponent = '0;
    in_if.b_mantissa = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (i = 0; i < directed.size() + N_RANDOM; i++) begin
      op = (i < directed.size()) ? directed[i].op : random_operands();
      calm = (i / 200) % 3 == 1;
      gap = idle_gap();
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      in_if.valid <= 1'b1;
      in_if.command <= op.cmd;
      in_if.a_negative <= op.an;
      in_if.a_zero <= op.az;
      in_if.a_exponent <= op.ae;
      in_if.a_mantissa <= op.am;
      in_if.b_negative <= op.bn;
      in_if.b_zero <= op.bz;
      in_if.b_exponent <= op.be;
      in_if.b_mantissa <= op.bm;
      do @(posedge clk_i); while (!in_if.ready);
      if (i < directed.size() && directed[i].typed) begin
        sums_pending.push_back(directed[i].want);
      end else begin
        sums_pending.push_back(add_sub(op));
      end
      if (!op.az && !op.bz && op.ae == op.be && op.am == op.bm && (op.an ^ op.bn ^ op.cmd))
        n_cancel++;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b0;
    while (sums_pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Checked %0d words: zero shortcuts, exponent extremes, wide shifts,", n_checked);
    $display("%0d exact cancellations, random idling and a long output stall.", n_cancel);
    if (errors == 0 && sums_pending.size() == 0) begin
      $display("float_add_sub_64bit_mantissa test passed");
    end else begin
      $display("float_add_sub_64bit_mantissa test failed");
    end
    $finish;
  end

  // The receiver holds off for a long stretch once, so the pipeline fills and stalls its input.
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    repeat (400) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (60) @(posedge clk_i);
    hold_off = 1'b0;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_off) out_if.ready <= 1'b0;
      else if (calm) out_if.ready <= 1'b1;
      else if ($urandom_range(0, 99) < 3) out_if.ready <= 1'b0;
      else out_if.ready <= ($urandom_range(0, 99) < 75);
    end
  end

  always @(posedge clk_i) begin
    sum_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (sums_pending.size() == 0) begin
        $error("result word arrived with nothing expected");
        errors++;
      end else begin
        want = sums_pending.pop_front();
        n_checked++;
        if (out_if.r_negative !== want.neg) begin
          $error("r_negative: expected %0b, got %0b", want.neg, out_if.r_negative);
          errors++;
        end
        if (out_if.r_zero !== want.zero) begin
          $error("r_zero: expected %0b, got %0b", want.zero, out_if.r_zero);
          errors++;
        end
        if (out_if.r_exponent !== want.e) begin
          $error("r_exponent: expected %0d, got %0d", $signed(want.e),
                 $signed(out_if.r_exponent));
          errors++;
        end
        if (out_if.r_mantissa !== want.m) begin
          $error("r_mantissa: expected %h, got %h", want.m, out_if.r_mantissa);
          errors++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("float_add_sub_64bit_mantissa test failed");
    $finish;
  end
endmodule
`default_nettype wire
